// ----- sv/tms_pkg.sv -----
// ----------------------------------------------------------------------------
// tms_pkg
// Shared types and constants of the track motion selector.
// ----------------------------------------------------------------------------
package tms_pkg;

    localparam int QUEUE_DEPTH = 2;

    // register indexes, word address paddr[3:2]
    localparam logic [1:0] REG_SELECT_MODE  = 2'd0;
    localparam logic [1:0] REG_MIN_STEP     = 2'd1;
    localparam logic [1:0] REG_TOP_COUNT    = 2'd2;
    localparam logic [1:0] REG_TOP_FRACTION = 2'd3;

    localparam logic [1:0] MODE_THRESHOLD = 2'd0;
    localparam logic [1:0] MODE_TOP_COUNT = 2'd1;
    localparam logic [1:0] MODE_TOP_FRAC  = 2'd2;
    // unused encoding, decided like threshold mode
    localparam logic [1:0] MODE_RESERVED  = 2'd3;

    // one classified point handed from front to back
    typedef struct packed {
        logic        acc;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [19:0] gap;
        logic        track_end;
        logic        list_end;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  select_mode;
        logic [23:0] min_step;
        logic [6:0]  top_count;
        logic [16:0] top_fraction;
    } t_cfg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_SQSUM,
        S_ROOT,
        S_ACC,
        S_ENDCHK,
        S_DIV,
        S_STORE,
        S_TOUT,
        S_LEND,
        S_RANK,
        S_RDI,
        S_LATI,
        S_RDJ,
        S_CMPJ,
        S_CHK,
        S_ERD,
        S_ELAT,
        S_EOUT
    } t_state;

endpackage

// ----- sv/tms_front.sv -----
// ----------------------------------------------------------------------------
// tms_front
// Accepts points, tracks the previous point and classifies each one.
// ----------------------------------------------------------------------------
module tms_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [55:0]        i_data,
    input  logic [1:0]         i_user,
    input  logic               i_last,
    input  logic               i_full,
    output logic               o_ready,
    output logic               o_push,
    output tms_pkg::t_cmd      o_cmd
);
    import tms_pkg::*;

    logic [15:0] r_prev_x;
    logic [15:0] r_prev_y;
    logic [19:0] r_prev_t;
    logic        r_fresh;

    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [19:0] frame_t;
    logic        ends;

    assign pos_x   = i_data[15:0];
    assign pos_y   = i_data[31:16];
    assign frame_t = i_data[51:32];
    assign ends    = i_user[1] | i_last;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_cmd.acc       = !i_user[0] && !r_fresh;
        o_cmd.dx        = (pos_x > r_prev_x) ? pos_x - r_prev_x : r_prev_x - pos_x;
        o_cmd.dy        = (pos_y > r_prev_y) ? pos_y - r_prev_y : r_prev_y - pos_y;
        o_cmd.gap       = frame_t - r_prev_t;
        o_cmd.track_end = ends;
        o_cmd.list_end  = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_prev_t <= '0;
            r_fresh  <= 1'b1;
        end else if (o_push) begin
            r_prev_x <= pos_x;
            r_prev_y <= pos_y;
            r_prev_t <= frame_t;
            r_fresh  <= ends;
        end
    end

endmodule

// ----- sv/tms_queue.sv -----
// ----------------------------------------------------------------------------
// tms_queue
// Short queue of classified points between front and back.
// ----------------------------------------------------------------------------
module tms_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tms_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_empty,
    output tms_pkg::t_cmd      o_cmd
);
    import tms_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- sv/tms_back.sv -----
// ----------------------------------------------------------------------------
// tms_back
// Step length, running sums, average division, track store and ranking.
// ----------------------------------------------------------------------------
module tms_back #(
    parameter int MAX_TRACKS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tms_pkg::t_cfg      i_cfg,
    input  logic               i_empty,
    input  tms_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    output logic [31:0]        o_data,  // track_number[5:0], average_step[29:6], zero pad
    output logic               o_user,  // keep
    output logic               o_last,  // last_result
    input  logic               i_ready
);
    import tms_pkg::*;

    localparam int CW = $clog2(MAX_TRACKS + 1);
    localparam int IW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

    t_state       r_state;
    t_state       n_state;
    t_cmd         r_cmd;

    logic [31:0]  r_prod_x;
    logic [31:0]  r_prod_y;
    logic [41:0]  r_rad;
    logic [22:0]  r_rem;
    logic [20:0]  r_root;
    logic [4:0]   r_cnt;
    logic [31:0]  r_dist;
    logic [23:0]  r_dur;
    logic [31:0]  r_dq;
    logic [24:0]  r_drem;
    logic [23:0]  r_avg;
    logic         r_valid;
    logic [CW-1:0] r_tnum;
    logic [CW-1:0] r_count;
    logic [6:0]   r_n;
    logic [IW-1:0] r_i;
    logic [IW-1:0] r_j;
    logic [CW-1:0] r_gt;
    logic [CW-1:0] r_ge;
    logic [23:0]  r_vi;
    logic [23:0]  r_thr;

    logic [24:0]  r_store [MAX_TRACKS];
    logic [24:0]  r_rdata;

    logic         r_ovalid;
    logic [31:0]  r_odata;
    logic         r_ouser;
    logic         r_olast;

    // control
    logic          ranking;
    logic          out_free;
    logic          out_load;
    logic [31:0]   out_data;
    logic          out_keep;
    logic          out_last;
    logic          mem_we;
    logic [IW-1:0] mem_raddr;
    logic [IW-1:0] cur_idx;

    // datapath helpers
    logic [24:0]  sq_t;
    logic [24:0]  sq_trial;
    logic [32:0]  dist_add;
    logic [24:0]  dur_add;
    logic [24:0]  div_t;
    logic [23:0]  avg_sat;
    logic [CW-1:0] count_m1;
    logic [23:0]  frac_prod;
    logic [7:0]   n_cand;
    logic         last_emit;
    logic [6:0]   tnum7;

    assign ranking  = (i_cfg.select_mode == MODE_TOP_COUNT) ||
                      (i_cfg.select_mode == MODE_TOP_FRAC);
    assign out_free = !r_ovalid || i_ready;

    assign sq_t     = {r_rem, r_rad[41:40]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign dist_add = {1'b0, r_dist} + {12'd0, r_root};
    assign dur_add  = {1'b0, r_dur} + {5'd0, r_cmd.gap};
    assign div_t    = {r_drem[23:0], r_dq[31]};
    assign avg_sat  = (r_dur == '0) ? 24'd0 :
                      ((r_dq[31:24] != 8'd0) ? 24'hFFFFFF : r_dq[23:0]);
    assign count_m1 = r_count - 1'b1;
    assign frac_prod = 24'(i_cfg.top_fraction) * 24'(count_m1);
    assign n_cand   = (i_cfg.select_mode == MODE_TOP_COUNT) ? {1'b0, i_cfg.top_count}
                                                            : frac_prod[23:16];
    assign last_emit = (CW'(r_i) == count_m1);
    assign tnum7    = 7'(r_tnum);
    assign cur_idx  = IW'(r_count);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (!i_empty) n_state = i_cmd.acc ? S_SQX : S_ENDCHK;
            S_SQX:    n_state = S_SQY;
            S_SQY:    n_state = S_SQSUM;
            S_SQSUM:  n_state = S_ROOT;
            S_ROOT:   if (r_cnt == 5'd20) n_state = S_ACC;
            S_ACC:    n_state = S_ENDCHK;
            S_ENDCHK: begin
                if (!r_cmd.track_end) begin
                    n_state = S_IDLE;
                end else if (r_dur == '0) begin
                    n_state = S_STORE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV:    if (r_cnt == 5'd31) n_state = S_STORE;
            S_STORE:  n_state = ranking ? S_LEND : S_TOUT;
            S_TOUT:   if (out_free) n_state = S_LEND;
            S_LEND: begin
                if (r_cmd.list_end && ranking && (r_count != '0)) begin
                    n_state = S_RANK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RANK:   n_state = S_RDI;
            S_RDI:    n_state = S_LATI;
            S_LATI:   n_state = S_RDJ;
            S_RDJ:    n_state = S_CMPJ;
            S_CMPJ:   if (CW'(r_j) + 1'b1 == r_count) n_state = S_CHK;
                      else n_state = S_RDJ;
            S_CHK: begin
                if (({1'b0, r_gt} <= {1'b0, r_n}) && ({1'b0, r_n} < {1'b0, r_ge})) begin
                    n_state = S_ERD;
                end else begin
                    n_state = S_RDI;
                end
            end
            S_ERD:    n_state = S_ELAT;
            S_ELAT:   n_state = S_EOUT;
            S_EOUT:   if (out_free) n_state = last_emit ? S_IDLE : S_ERD;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_pop     = 1'b0;
        out_load  = 1'b0;
        out_keep  = 1'b0;
        out_last  = 1'b0;
        out_data  = '0;
        mem_we    = 1'b0;
        mem_raddr = r_i;
        case (r_state)
            S_IDLE:  o_pop = !i_empty;
            S_STORE: mem_we = (r_count < CW'(MAX_TRACKS));
            S_TOUT: begin
                out_load = out_free;
                out_data = {2'b00, r_avg, tnum7[5:0]};
                out_keep = r_valid && (r_avg >= i_cfg.min_step);
                out_last = 1'b1;
            end
            S_RDJ:   mem_raddr = r_j;
            S_EOUT: begin
                out_load = out_free;
                out_data = {2'b00, r_avg, 6'(r_i)};
                out_keep = r_valid && (r_avg >= r_thr);
                out_last = last_emit;
            end
            default: ;
        endcase
    end

    // track store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[cur_idx] <= {(r_dur != '0), avg_sat};
        end
        r_rdata <= r_store[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dist  <= '0;
            r_dur   <= '0;
            r_count <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_ACC: begin
                    r_dist <= (dist_add[32]) ? 32'hFFFFFFFF : dist_add[31:0];
                    r_dur  <= (dur_add[24]) ? 24'hFFFFFF : dur_add[23:0];
                end
                S_STORE: begin
                    if (r_count < CW'(MAX_TRACKS)) r_count <= r_count + 1'b1;
                    r_dist <= '0;
                    r_dur  <= '0;
                end
                S_LEND: begin
                    if (r_cmd.list_end && !(ranking && (r_count != '0))) r_count <= '0;
                end
                S_EOUT: begin
                    if (out_free && last_emit) r_count <= '0;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_odata <= out_data;
            r_ouser <= out_keep;
            r_olast <= out_last;
        end
        case (r_state)
            S_IDLE:  if (!i_empty) r_cmd <= i_cmd;
            S_SQX:   r_prod_x <= r_cmd.dx * r_cmd.dx;
            S_SQY:   r_prod_y <= r_cmd.dy * r_cmd.dy;
            S_SQSUM: begin
                r_rad  <= {1'b0, ({1'b0, r_prod_x} + {1'b0, r_prod_y}), 8'd0};
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end
            S_ROOT: begin
                // one result bit per cycle
                if (sq_t >= sq_trial) begin
                    r_rem  <= 23'(sq_t - sq_trial);
                    r_root <= {r_root[19:0], 1'b1};
                end else begin
                    r_rem  <= sq_t[22:0];
                    r_root <= {r_root[19:0], 1'b0};
                end
                r_rad <= {r_rad[39:0], 2'b00};
                r_cnt <= r_cnt + 1'b1;
            end
            S_ENDCHK: begin
                r_dq   <= r_dist;
                r_drem <= '0;
                r_cnt  <= '0;
            end
            S_DIV: begin
                if (div_t >= {1'b0, r_dur}) begin
                    r_drem <= div_t - {1'b0, r_dur};
                    r_dq   <= {r_dq[30:0], 1'b1};
                end else begin
                    r_drem <= div_t;
                    r_dq   <= {r_dq[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
            end
            S_STORE: begin
                r_avg   <= avg_sat;
                r_valid <= (r_dur != '0);
                r_tnum  <= r_count;
            end
            S_RANK: begin
                r_n <= (n_cand > 8'(count_m1)) ? 7'(count_m1) : n_cand[6:0];
                r_i <= '0;
            end
            S_LATI: begin
                r_vi <= r_rdata[23:0];
                r_j  <= '0;
                r_gt <= '0;
                r_ge <= '0;
            end
            S_CMPJ: begin
                if (r_rdata[23:0] > r_vi)  r_gt <= r_gt + 1'b1;
                if (r_rdata[23:0] >= r_vi) r_ge <= r_ge + 1'b1;
                r_j <= r_j + 1'b1;
            end
            S_CHK: begin
                if (({1'b0, r_gt} <= {1'b0, r_n}) && ({1'b0, r_n} < {1'b0, r_ge})) begin
                    r_thr <= r_vi;
                    r_i   <= '0;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            S_ELAT: begin
                r_avg   <= r_rdata[23:0];
                r_valid <= r_rdata[24];
            end
            S_EOUT:  if (out_free && !last_emit) r_i <= r_i + 1'b1;
            default: ;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_user  = r_ouser;
    assign o_last  = r_olast;

endmodule

// ----- sv/track_motion_selector_core.sv -----
// ----------------------------------------------------------------------------
// track_motion_selector_core
// Motion based track selection over streamed tracked points.
//
//   channel  direction  contents
//   s_*      in         one tracked point per request
//   m_*      out        one keep decision per request
//   apb      in/out     select_mode, min_step, top_count, top_fraction
//
// A point with a step takes two squares and a bit-serial square root; a track
// end adds the 32-step divider unless its duration is zero, the store and,
// outside the ranking modes, the decision. At list end in a ranking mode
// the store is scanned pairwise over its N tracks, then N decisions follow.
// Synchronous active-low reset; the store needs no clearing pass.
// The input queue holds two points; the output register decouples stalls.
// ----------------------------------------------------------------------------
module track_motion_selector_core #(
    parameter int MAX_TRACKS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // pos_x, pos_y, frame_time, zero pad
    input  logic [1:0]  s_tuser,   // view_start, track_end
    input  logic        s_tlast,   // list_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // track_number, average_step, zero pad
    output logic        m_tuser,   // keep
    output logic        m_tlast,   // last_result
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tms_pkg::*;

    logic [1:0]  r_select_mode;
    logic [23:0] r_min_step;
    logic [6:0]  r_top_count;
    logic [16:0] r_top_fraction;

    t_cfg cfg;
    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_select_mode  <= MODE_THRESHOLD;
            r_min_step     <= '0;
            r_top_count    <= 7'd1;
            r_top_fraction <= '0;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_SELECT_MODE:  r_select_mode  <= pwdata[1:0];
                REG_MIN_STEP:     r_min_step     <= pwdata[23:0];
                REG_TOP_COUNT:    r_top_count    <= pwdata[6:0];
                REG_TOP_FRACTION: r_top_fraction <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SELECT_MODE:  prdata = {30'd0, r_select_mode};
            REG_MIN_STEP:     prdata = {8'd0, r_min_step};
            REG_TOP_COUNT:    prdata = {25'd0, r_top_count};
            REG_TOP_FRACTION: prdata = {15'd0, r_top_fraction};
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        cfg.select_mode  = r_select_mode;
        cfg.min_step     = r_min_step;
        cfg.top_count    = r_top_count;
        cfg.top_fraction = r_top_fraction;
    end

    tms_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .i_data  (s_tdata),
        .i_user  (s_tuser),
        .i_last  (s_tlast),
        .i_full  (full),
        .o_ready (s_tready),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    tms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (queue_cmd)
    );

    tms_back #(
        .MAX_TRACKS (MAX_TRACKS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_empty (empty),
        .i_cmd   (queue_cmd),
        .o_pop   (pop),
        .o_valid (m_tvalid),
        .o_data  (m_tdata),
        .o_user  (m_tuser),
        .o_last  (m_tlast),
        .i_ready (m_tready)
    );

    // threshold decisions are always single and final
    a_thr_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (r_select_mode == MODE_THRESHOLD)) |-> m_tlast)
        else $error("threshold result without last flag");

    a_thr_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser && (r_select_mode == MODE_THRESHOLD))
            |-> (m_tdata[29:6] >= r_min_step))
        else $error("kept track below threshold");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule
